### rtl/mrfb_pkg.sv
// Package with the word types, mode codes and CRC-16/Modbus helper of the frame builder.
package mrfb_pkg;

   // Mode codes of a request word.
   localparam logic [1:0] MODE_READ_REQ  = 2'd0;
   localparam logic [1:0] MODE_WRITE_REG = 2'd1;
   localparam logic [1:0] MODE_READ_RSP  = 2'd2;
   // The mode code that builds no frame.
   localparam logic [1:0] MODE_UNUSED    = 2'd3;

   // Modbus function codes and fixed payload bytes.
   localparam logic [7:0] FUNC_READ_INPUT  = 8'h04;
   localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] BYTE_COUNT_TWO   = 8'h02;
   localparam logic [7:0] QUANTITY_HI      = 8'h00;
   localparam logic [7:0] QUANTITY_LO      = 8'h01;

   // CRC-16/Modbus: initial value and reflected polynomial.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Longest frame in bytes.
   localparam int unsigned FRAME_MAX = 8;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  slave_id;
      logic [15:0] reg_address;
      logic [15:0] reg_value;
   } req_word_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } rsp_word_type;

   // Body bytes of one frame before the CRC, with the number of them.
   typedef struct packed {
      logic [FRAME_MAX-1:0][7:0] body;
      logic [2:0]                body_len;
   } frame_type;

   // Folds one byte into the running CRC, one bit per step.
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

### rtl/mrfb_assemble.sv
// Builds the body bytes and body length of a frame from one request word.
module mrfb_assemble
   import mrfb_pkg::*;
(
   input  req_word_type req_word,
   output frame_type    frame
);

   // Lay out the body bytes for the selected mode; unused bytes stay zero.
   always_comb begin
      frame         = '0;
      frame.body[0] = req_word.slave_id;
      case (req_word.mode)
         MODE_READ_REQ: begin
            frame.body[1]  = FUNC_READ_INPUT;
            frame.body[2]  = req_word.reg_address[15:8];
            frame.body[3]  = req_word.reg_address[7:0];
            frame.body[4]  = QUANTITY_HI;
            frame.body[5]  = QUANTITY_LO;
            frame.body_len = 3'd6;
         end
         MODE_WRITE_REG: begin
            frame.body[1]  = FUNC_WRITE_SINGLE;
            frame.body[2]  = req_word.reg_address[15:8];
            frame.body[3]  = req_word.reg_address[7:0];
            frame.body[4]  = req_word.reg_value[15:8];
            frame.body[5]  = req_word.reg_value[7:0];
            frame.body_len = 3'd6;
         end
         MODE_READ_RSP: begin
            frame.body[1]  = FUNC_READ_INPUT;
            frame.body[2]  = BYTE_COUNT_TWO;
            frame.body[3]  = req_word.reg_value[15:8];
            frame.body[4]  = req_word.reg_value[7:0];
            frame.body_len = 3'd5;
         end
         default: begin
            // A request with the unused mode is never marked valid, so it is never loaded.
            frame.body_len = 3'd0;
         end
      endcase
   end

endmodule

### rtl/mrfb_serialiser.sv
// Sends a frame one byte per word, folding the CRC as the body goes out.
module mrfb_serialiser
   import mrfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load_valid,
   input  frame_type    frame,
   output logic         load_take,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         active_ff, active_in;
   logic [2:0]   idx_ff, idx_in;
   logic [15:0]  crc_ff, crc_in;
   frame_type    frame_ff, frame_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic        advance;
   logic        emit;
   logic        at_last;
   logic        in_body;
   logic        do_load;
   logic [7:0]  byte_out;

   // The output register moves on when empty or when its word is taken.
   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign emit     = active_ff && advance;
   assign at_last  = (idx_ff == frame_ff.body_len + 3'd1);
   assign in_body  = (idx_ff < frame_ff.body_len);
   assign load_take = !active_ff || (emit && at_last);
   assign do_load  = load_take && load_valid;

   // Pick the byte at the current position: body, then CRC low, then CRC high.
   always_comb begin
      if (in_body) begin
         byte_out = frame_ff.body[idx_ff];
      end else if (idx_ff == frame_ff.body_len) begin
         byte_out = crc_ff[7:0];
      end else begin
         byte_out = crc_ff[15:8];
      end
   end

   // Next values of the sequencing and CRC registers.
   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_word_in.tx_byte = byte_out;
         rsp_word_in.last    = at_last;
         idx_in              = idx_ff + 3'd1;
         if (in_body) begin
            crc_in = crc_update(crc_ff, byte_out);
         end
         if (at_last) begin
            active_in = 1'b0;
         end
      end
      if (do_load) begin
         active_in = 1'b1;
         idx_in    = 3'd0;
         crc_in    = CRC_INIT;
         frame_in  = frame;
      end
   end

   // Control registers take reset; the payload registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      crc_ff      <= crc_in;
      frame_ff    <= frame_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### rtl/modbus_rtu_frame_builder.sv
// Top level of the Modbus RTU frame builder: request register and byte serialiser.
//
//   Channel   Direction  Handshake            Word
//   req_      in         req_valid/req_stall  req_word_type (mode, slave, address, value)
//   rsp_      out        rsp_valid/rsp_stall  rsp_word_type (tx_byte, last)
//
// A frame goes out one byte per cycle while rsp_stall is low: eight bytes for modes 0
// and 1, seven for mode 2. The next request is held in the request register and loaded
// in the cycle the last byte goes out, so frames follow without a gap. A request with
// the unused mode is taken and dropped with no output. Reset is synchronous and clears
// only the valid and busy flags. A stall on rsp_ holds the output word and pauses the
// serialiser; req_stall rises once the request register is full and the serialiser
// cannot take it.
module modbus_rtu_frame_builder
   import mrfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         req_valid_ff, req_valid_in;
   req_word_type req_word_ff, req_word_in;

   logic      load_take;
   logic      req_accept;
   frame_type frame;

   // Request register: filled on accept, emptied when the serialiser loads it.
   assign req_stall  = req_valid_ff && !load_take;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_word_in  = req_word_ff;
      if (load_take) begin
         req_valid_in = 1'b0;
      end
      if (req_accept) begin
         req_valid_in = (req_word.mode != MODE_UNUSED);
         req_word_in  = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      req_word_ff <= req_word_in;
   end

   // Frame layout from the held request.
   mrfb_assemble u_assemble (
      .req_word (req_word_ff),
      .frame    (frame)
   );

   // Byte sequencing and CRC.
   mrfb_serialiser u_serialiser (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_valid_ff),
      .frame      (frame),
      .load_take  (load_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule
